@@ rtl/scie_pkg.sv @@
// Shared types and constants for the instruction execute core.
// Used by scie_exec, the top level and the port checker.
`timescale 1ns / 1ps

package scie_pkg;

	localparam int REG_COUNT_DEF  = 32;
	localparam int BANK_WORDS_DEF = 1024;
	localparam int BANK_COUNT_DEF = 4;
	localparam int PROGRAM_DEPTH  = 1024;
	localparam int TAKEN_PENALTY  = 2;

	// width of a register index field and the count of codes it can carry
	localparam int REG_FIELD_W = 5;
	localparam int REG_FIELD_N = 2 ** REG_FIELD_W;

	localparam logic [3:0] OP_ADD  = 4'd0;
	localparam logic [3:0] OP_SUB  = 4'd1;
	localparam logic [3:0] OP_MUL  = 4'd2;
	localparam logic [3:0] OP_ADDI = 4'd3;
	localparam logic [3:0] OP_LD   = 4'd4;
	localparam logic [3:0] OP_LDC2 = 4'd5;
	localparam logic [3:0] OP_LDC3 = 4'd6;
	localparam logic [3:0] OP_LDC4 = 4'd7;
	localparam logic [3:0] OP_SW   = 4'd8;
	localparam logic [3:0] OP_BNE  = 4'd9;
	localparam logic [3:0] OP_J    = 4'd10;
	localparam logic [3:0] OP_DIV  = 4'd11;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_FORWARDING = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CORE       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ADD_LAT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SUB_LAT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MUL_LAT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DIV_LAT    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PROG_LEN   = 3'd6;

	typedef struct packed {
		logic [3:0]         req_type;
		logic [4:0]         dest_reg;
		logic [4:0]         src_reg_a;
		logic [4:0]         src_reg_b;
		logic signed [31:0] immediate;
		logic [9:0]         mem_address;
		logic               label_found;
		logic [9:0]         label_target;
	} scie_req_t;

	typedef struct packed {
		logic               ignored;
		logic [10:0]        next_pc;
		logic               reg_written;
		logic [4:0]         written_reg;
		logic signed [31:0] written_value;
		logic [31:0]        instr_total;
		logic [31:0]        cycle_total;
		logic [31:0]        stall_total;
	} scie_result_t;

	typedef struct packed {
		logic        forwarding_enable;
		logic [1:0]  core_number;
		logic [7:0]  add_latency;
		logic [7:0]  sub_latency;
		logic [7:0]  mul_latency;
		logic [7:0]  div_latency;
		logic [10:0] program_length;
	} scie_cfg_t;

	// execute-stage decisions handed back to the top level
	typedef struct packed {
		logic        wr;
		logic [31:0] wval;
		logic        taken;
		logic        store;
		logic [7:0]  cyc_add;
		logic [31:0] stall_add;
	} scie_exec_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} scie_state_t;

endpackage

@@ rtl/scie_exec.sv @@
// Execute-stage logic: ALU, load/store/branch decisions and counter increments.
// Depends on scie_pkg.
`timescale 1ns / 1ps

module scie_exec (
	input  logic [3:0]         op,
	input  logic [31:0]        opnd_a,
	input  logic [31:0]        opnd_b,
	input  logic [31:0]        imm,
	input  logic [31:0]        mem_data,
	input  logic               bank_ok,
	input  logic               found,
	input  scie_pkg::scie_cfg_t cfg,
	output scie_pkg::scie_exec_t ex
);
	import scie_pkg::*;

	logic [7:0]  lat;
	logic [31:0] stall_base;

	always_comb begin
		unique case (op)
			OP_ADD:  lat = cfg.add_latency;
			OP_SUB:  lat = cfg.sub_latency;
			OP_MUL:  lat = cfg.mul_latency;
			OP_DIV:  lat = cfg.div_latency;
			default: lat = 8'd1;
		endcase
	end

	// with forwarding off, a zero latency wraps the stall increment to all ones
	assign stall_base = cfg.forwarding_enable ? 32'd0 : (32'(lat) - 32'd1);

	always_comb begin
		ex       = '0;
		ex.cyc_add = cfg.forwarding_enable ? 8'd1 : lat;
		unique case (op) inside
			OP_ADD: begin
				ex.wr   = 1'b1;
				ex.wval = opnd_a + opnd_b;
			end
			OP_SUB: begin
				ex.wr   = 1'b1;
				ex.wval = opnd_a - opnd_b;
			end
			OP_MUL: begin
				ex.wr   = 1'b1;
				ex.wval = opnd_a * opnd_b;
			end
			OP_ADDI: begin
				ex.wr   = 1'b1;
				ex.wval = opnd_a + imm;
			end
			OP_LD: begin
				ex.wr   = bank_ok;
				ex.wval = bank_ok ? mem_data : 32'd0;
			end
			OP_LDC2, OP_LDC3, OP_LDC4: begin
				// cross-bank loads only land on core zero
				ex.wr   = bank_ok && (cfg.core_number == 2'd0);
				ex.wval = ex.wr ? mem_data : 32'd0;
			end
			OP_SW:   ex.store = bank_ok;
			OP_BNE:  ex.taken = (opnd_a != opnd_b) && found;
			OP_J:    ex.taken = found;
			default: ;
		endcase
		ex.stall_add = stall_base + (ex.taken ? 32'(TAKEN_PENALTY) : 32'd0);
	end

endmodule

@@ rtl/simple_core_instruction_execute_core.sv @@
// An accepted item is held in the stage-1 capture registers (state EXEC), then in the
// result register, which raises done. No new item is taken while busy is high, that is
// until the register-file / bank-memory read and the write-back of the last one are through.
// Reset: counters, pc and configuration clear at once; then a clearing pass over
// max(BANK_COUNT*BANK_WORDS, REG_COUNT) entries (4096 by default) zeroes the memories
// with busy high. The receiver cannot stall: each result is shown for one cycle.
`timescale 1ns / 1ps

module simple_core_instruction_execute_core #(
	parameter int REG_COUNT  = scie_pkg::REG_COUNT_DEF,
	parameter int BANK_WORDS = scie_pkg::BANK_WORDS_DEF,
	parameter int BANK_COUNT = scie_pkg::BANK_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  scie_pkg::scie_req_t                req,
	output logic                               done,
	output scie_pkg::scie_result_t             result,
	input  logic                               cfg_wr_en,
	input  logic [scie_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [scie_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import scie_pkg::*;

	localparam int RIDX_W     = $clog2(REG_COUNT);
	localparam int MEM_DEPTH  = BANK_COUNT * BANK_WORDS;
	localparam int MEM_AW     = $clog2(MEM_DEPTH);
	localparam int CLEAR_LEN  = (MEM_DEPTH > REG_COUNT) ? MEM_DEPTH : REG_COUNT;
	localparam int CLR_W      = $clog2(CLEAR_LEN);
	localparam int RECIP_SH   = 24;
	localparam int WORD_RECIP = ((1 << RECIP_SH) + BANK_WORDS - 1) / BANK_WORDS;

	scie_state_t state_q, state_d;
	scie_cfg_t   cfg_q;
	scie_exec_t  ex;

	logic [CLR_W-1:0]  clr_q;
	logic              clr_last;
	logic [10:0]       pc_q;
	logic [31:0]       instr_q, cycle_q, stall_q;

	logic              accept, exec_go, ignored_now;
	logic [RIDX_W-1:0] reg_fold [REG_FIELD_N];
	logic [RIDX_W-1:0] ra_idx, rb_idx, rd_idx, rb_port;
	logic [2:0]        bank_sel;
	logic              bank_ok;
	logic [30:0]       word_prod;
	logic [6:0]        word_q;
	logic [10:0]       word_idx;
	logic [31:0]       slot_full;
	logic [MEM_AW-1:0] slot;

	// stage 1 (read done, execute and write back)
	logic [3:0]        op_s1;
	logic [RIDX_W-1:0] rd_s1;
	logic [31:0]       imm_s1;
	logic              found_s1;
	logic [9:0]        target_s1;
	logic [MEM_AW-1:0] slot_s1;
	logic              bank_ok_s1;
	logic              ignored_s1;
	logic [31:0]       rf_a_s1, rf_b_s1, mem_rd_s1;

	logic [31:0]       rf_mem   [REG_COUNT];
	logic [31:0]       data_mem [MEM_DEPTH];
	logic              rf_we, mem_we;
	logic [RIDX_W-1:0] rf_waddr;
	logic [31:0]       rf_wdata;
	logic [MEM_AW-1:0] mem_waddr;
	logic [31:0]       mem_wdata;

	logic              done_q, res_ignored_q, res_wr_q;
	logic [4:0]        res_wreg_q;
	logic [31:0]       res_wval_q;

	// register index folding table, evaluated at elaboration
	for (genvar gi = 0; gi < REG_FIELD_N; gi++) begin : g_fold
		assign reg_fold[gi] = RIDX_W'(gi % REG_COUNT);
	end

	assign ra_idx  = reg_fold[req.src_reg_a];
	assign rb_idx  = reg_fold[req.src_reg_b];
	assign rd_idx  = reg_fold[req.dest_reg];
	assign rb_port = (req.req_type == OP_SW) ? rd_idx : rb_idx;

	assign clr_last    = (clr_q == CLR_W'(CLEAR_LEN - 1));
	assign accept      = (state_q == ST_IDLE) && start;
	assign exec_go     = (state_q == ST_EXEC);
	assign busy        = (state_q != ST_IDLE);
	assign ignored_now = (32'(pc_q) >= 32'(cfg_q.program_length)) ||
	                     (32'(pc_q) >= 32'(PROGRAM_DEPTH));

	always_comb begin
		case (req.req_type) inside
			OP_LDC2, OP_LDC3, OP_LDC4:
				bank_sel = 3'(cfg_q.core_number) + 3'(req.req_type - OP_LD);
			default:
				bank_sel = 3'(cfg_q.core_number);
		endcase
	end
	assign bank_ok = 32'(bank_sel) < 32'(BANK_COUNT);

	// word address modulo BANK_WORDS through a reciprocal; exact for 10-bit addresses when BANK_WORDS >= 8
	assign word_prod = 31'(req.mem_address) * 31'(WORD_RECIP);
	assign word_q    = word_prod[30:24];
	assign word_idx  = (BANK_WORDS >= 1024) ? 11'(req.mem_address) :
	                   11'(req.mem_address) - 11'(word_q) * 11'(BANK_WORDS);
	assign slot_full = 32'(bank_sel) * 32'(BANK_WORDS) + 32'(word_idx);
	assign slot      = MEM_AW'(slot_full);

	// FSM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_last) state_d = ST_IDLE;
			ST_IDLE:  if (start) state_d = ST_EXEC;
			ST_EXEC:  state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + CLR_W'(1);
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.forwarding_enable <= 1'b0;
			cfg_q.core_number       <= 2'd0;
			cfg_q.add_latency       <= 8'd1;
			cfg_q.sub_latency       <= 8'd1;
			cfg_q.mul_latency       <= 8'd1;
			cfg_q.div_latency       <= 8'd1;
			cfg_q.program_length    <= 11'd0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_FORWARDING: cfg_q.forwarding_enable <= cfg_data[0];
				CFG_CORE:       cfg_q.core_number       <= cfg_data[1:0];
				CFG_ADD_LAT:    cfg_q.add_latency       <= cfg_data[7:0];
				CFG_SUB_LAT:    cfg_q.sub_latency       <= cfg_data[7:0];
				CFG_MUL_LAT:    cfg_q.mul_latency       <= cfg_data[7:0];
				CFG_DIV_LAT:    cfg_q.div_latency       <= cfg_data[7:0];
				CFG_PROG_LEN:   cfg_q.program_length    <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1 capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= req.req_type;
			rd_s1      <= rd_idx;
			imm_s1     <= req.immediate;
			found_s1   <= req.label_found;
			target_s1  <= req.label_target;
			slot_s1    <= slot;
			bank_ok_s1 <= bank_ok;
			ignored_s1 <= ignored_now;
		end
	end

	scie_exec u_exec (
		.op       (op_s1),
		.opnd_a   (rf_a_s1),
		.opnd_b   (rf_b_s1),
		.imm      (imm_s1),
		.mem_data (mem_rd_s1),
		.bank_ok  (bank_ok_s1),
		.found    (found_s1),
		.cfg      (cfg_q),
		.ex       (ex)
	);

	// write ports: clearing pass, then execute write-back
	always_comb begin
		if (state_q == ST_CLEAR) begin
			rf_we     = 32'(clr_q) < 32'(REG_COUNT);
			rf_waddr  = RIDX_W'(clr_q);
			rf_wdata  = 32'd0;
			mem_we    = 32'(clr_q) < 32'(MEM_DEPTH);
			mem_waddr = MEM_AW'(clr_q);
			mem_wdata = 32'd0;
		end else begin
			rf_we     = exec_go && !ignored_s1 && ex.wr;
			rf_waddr  = rd_s1;
			rf_wdata  = ex.wval;
			mem_we    = exec_go && !ignored_s1 && ex.store;
			mem_waddr = slot_s1;
			mem_wdata = rf_b_s1;
		end
	end

	// register file: two read ports, one write port; busy interlocks read after write
	always_ff @(posedge clk) begin
		if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
		if (accept) begin
			rf_a_s1 <= rf_mem[ra_idx];
			rf_b_s1 <= rf_mem[rb_port];
		end
	end

	// bank memory
	always_ff @(posedge clk) begin
		if (mem_we) data_mem[mem_waddr] <= mem_wdata;
		if (accept) mem_rd_s1 <= data_mem[slot];
	end

	// architectural counters and pc
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= '0;
			instr_q <= '0;
			cycle_q <= '0;
			stall_q <= '0;
		end else if (exec_go && !ignored_s1) begin
			pc_q    <= ex.taken ? 11'(target_s1) : pc_q + 11'd1;
			instr_q <= instr_q + 32'd1;
			cycle_q <= cycle_q + 32'(ex.cyc_add);
			stall_q <= stall_q + ex.stall_add;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= exec_go;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			res_ignored_q <= ignored_s1;
			res_wr_q      <= !ignored_s1 && ex.wr;
			res_wreg_q    <= (!ignored_s1 && ex.wr) ? 5'(rd_s1) : 5'd0;
			res_wval_q    <= (!ignored_s1 && ex.wr) ? ex.wval : 32'd0;
		end
	end

	// pc and counters only move in the execute state, so they hold while done is shown
	assign done                 = done_q;
	assign result.ignored       = res_ignored_q;
	assign result.next_pc       = pc_q;
	assign result.reg_written   = res_wr_q;
	assign result.written_reg   = res_wreg_q;
	assign result.written_value = res_wval_q;
	assign result.instr_total   = instr_q;
	assign result.cycle_total   = cycle_q;
	assign result.stall_total   = stall_q;

endmodule

@@ rtl/scie_checker.sv @@
// Port-level checker for the instruction execute core, attached by bind.
// Depends on scie_pkg and simple_core_instruction_execute_core.
`timescale 1ns / 1ps

module scie_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   done,
	input scie_pkg::scie_result_t result
);
	import scie_pkg::*;

	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted item gave no result two cycles later");

	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("not busy after an accepted transfer");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_quiet_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.ignored || !result.reg_written)) |->
		(!result.reg_written && result.written_reg == 5'd0 && result.written_value == 32'sd0))
		else $error("write fields set on a result with no register write");

endmodule

bind simple_core_instruction_execute_core scie_checker u_scie_checker (.*);
